// ===== src/psr_pkg.sv =====
// Shared constants and types for the point-to-segment radius test.
// No dependencies; imported by the top level and the checker.
package psr_pkg;

   // Default coordinate width in bits (supported range 8 to 32)
   localparam int COORD_BITS_DEF = 20;

   // Configuration register index width and register map
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_END_A_X = 3'd0,
      CSR_END_A_Y = 3'd1,
      CSR_END_A_Z = 3'd2,
      CSR_END_B_X = 3'd3,
      CSR_END_B_Y = 3'd4,
      CSR_END_B_Z = 3'd5,
      CSR_RADIUS  = 3'd6
   } csr_index_type;

   // Register stages inside the wide multiplier
   localparam int MUL_STAGES = 3;

   // Cycles from an accepted request to its result strobe
   localparam int PIPE_LATENCY = 5 + MUL_STAGES;

endpackage

// ===== src/point_segment_radius_test.sv =====
// Point-to-segment radius test: top level with the full datapath pipeline.
// Depends on psr_pkg and psr_wide_mul.
//
// Usage
//   Configuration: write the segment endpoints A and B and the radius through
//   csr_write_en / csr_index / csr_data; a write takes effect at the clock
//   edge where csr_write_en is high. Write only while no request is in flight.
//   Requests: a point is transferred at a rising edge with start high and
//   busy low. busy is high only while reset is held, so a new point can be
//   transferred in every cycle.
//   Results: each point gives one rsp_inside_res, shown with rsp_valid for a
//   single cycle, in request order.
//   Throughput is one point per cycle; the pipeline has five datapath stages
//   (differences, products, sums, clamp decision, final compare) plus the
//   three stages of the wide multipliers that resolve the interior case.
//   The receiver cannot stall: results are never held back.
//   Reset (synchronous) clears the configuration to zero and drops every
//   point in flight; no result appears in the cycle after reset.
module point_segment_radius_test
   import psr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]         csr_data
);

   localparam int DW   = COORD_BITS + 1;       // coordinate differences
   localparam int PW   = 2 * COORD_BITS + 2;   // products and sums of squares
   localparam int DOTW = PW + 1;               // signed dot product
   localparam int RW   = COORD_BITS - 1;       // radius
   localparam int R2W  = 2 * RW;               // radius squared

   typedef struct packed {
      logic valid;
      logic known;
      logic value;
   } tag_type;

   // Configuration registers
   logic signed [COORD_BITS-1:0] end_a_ff [3];
   logic signed [COORD_BITS-1:0] end_b_ff [3];
   logic [RW-1:0]                radius_ff;

   // Stage 1: differences
   logic                 s1_valid_ff;
   logic signed [DW-1:0] ap_ff [3], ap_in [3];
   logic signed [DW-1:0] bp_ff [3], bp_in [3];
   logic signed [DW-1:0] ab_ff [3], ab_in [3];
   logic [RW-1:0]        s1_radius_ff;
   logic signed [COORD_BITS-1:0] point [3];

   // Stage 2: products
   logic                 s2_valid_ff;
   logic signed [PW-1:0] ap_sq_ff [3], ap_sq_in [3];
   logic signed [PW-1:0] bp_sq_ff [3], bp_sq_in [3];
   logic signed [PW-1:0] ab_sq_ff [3], ab_sq_in [3];
   logic signed [PW-1:0] ap_ab_ff [3], ap_ab_in [3];
   logic [R2W-1:0]       r2_ff, r2_in;

   // Stage 3: sums
   logic                   s3_valid_ff;
   logic [PW-1:0]          sap_ff, sap_in;
   logic [PW-1:0]          sbp_ff, sbp_in;
   logic [PW-1:0]          len2_ff, len2_in;
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic [R2W-1:0]         s3_r2_ff;

   // Stage 4: clamp decision and multiplier operands
   tag_type        s4_tag_ff, s4_tag_in;
   logic [PW-1:0]  excess_ff, excess_in;
   logic [PW-1:0]  proj_ff, proj_in;
   logic [PW-1:0]  s4_len2_ff;
   logic [PW-1:0]  r2_wide;
   logic           len_zero, dot_le_zero, dot_ge_len, near_a, near_b, excess_pos;

   // Multiplier stages and final compare
   tag_type         mul_tag_ff [MUL_STAGES];
   logic [2*PW-1:0] lhs_prod, rhs_prod;
   logic            out_valid_ff, out_inside_ff, out_inside_in;

   assign busy = reset;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            end_a_ff[i] <= '0;
            end_b_ff[i] <= '0;
         end
         radius_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_END_A_X: end_a_ff[0] <= csr_data;
            CSR_END_A_Y: end_a_ff[1] <= csr_data;
            CSR_END_A_Z: end_a_ff[2] <= csr_data;
            CSR_END_B_X: end_b_ff[0] <= csr_data;
            CSR_END_B_Y: end_b_ff[1] <= csr_data;
            CSR_END_B_Z: end_b_ff[2] <= csr_data;
            CSR_RADIUS:  radius_ff   <= csr_data[RW-1:0];
            default: ;
         endcase
      end
   end

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   // Stage 1: vectors from A to P, B to P and A to B
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ap_in[i] = DW'(point[i]) - DW'(end_a_ff[i]);
         bp_in[i] = DW'(point[i]) - DW'(end_b_ff[i]);
         ab_in[i] = DW'(end_b_ff[i]) - DW'(end_a_ff[i]);
      end
   end

   // Stage 2: squares, cross terms and radius squared
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ap_sq_in[i] = PW'(ap_ff[i]) * PW'(ap_ff[i]);
         bp_sq_in[i] = PW'(bp_ff[i]) * PW'(bp_ff[i]);
         ab_sq_in[i] = PW'(ab_ff[i]) * PW'(ab_ff[i]);
         ap_ab_in[i] = PW'(ap_ff[i]) * PW'(ab_ff[i]);
      end
      r2_in = R2W'(s1_radius_ff) * R2W'(s1_radius_ff);
   end

   // Stage 3: squared lengths and dot product
   assign sap_in  = $unsigned(ap_sq_ff[0]) + $unsigned(ap_sq_ff[1]) + $unsigned(ap_sq_ff[2]);
   assign sbp_in  = $unsigned(bp_sq_ff[0]) + $unsigned(bp_sq_ff[1]) + $unsigned(bp_sq_ff[2]);
   assign len2_in = $unsigned(ab_sq_ff[0]) + $unsigned(ab_sq_ff[1]) + $unsigned(ab_sq_ff[2]);
   assign dot_in  = DOTW'(ap_ab_ff[0]) + DOTW'(ap_ab_ff[1]) + DOTW'(ap_ab_ff[2]);

   // Stage 4: clamp the projection and settle every case but the interior one
   assign r2_wide     = PW'(s3_r2_ff);
   assign len_zero    = (len2_ff == '0);
   assign dot_le_zero = dot_ff[DOTW-1] || (dot_ff == '0);
   assign dot_ge_len  = (dot_ff >= $signed({1'b0, len2_ff}));
   assign near_a      = (sap_ff <= r2_wide);
   assign near_b      = (sbp_ff <= r2_wide);
   assign excess_pos  = !near_a;

   always_comb begin
      s4_tag_in.valid = s3_valid_ff;
      s4_tag_in.known = 1'b1;
      s4_tag_in.value = 1'b0;
      if (len_zero) begin
         s4_tag_in.value = near_b;
      end else if (dot_le_zero) begin
         s4_tag_in.value = near_a;
      end else if (dot_ge_len) begin
         s4_tag_in.value = near_b;
      end else if (!excess_pos) begin
         s4_tag_in.value = 1'b1;
      end else begin
         s4_tag_in.known = 1'b0;
      end
      // Interior test: (|AP|^2 - r^2) * len^2 <= dot^2
      excess_in = sap_ff - r2_wide;
      proj_in   = dot_ff[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_tag_ff   <= '0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_tag_ff   <= s4_tag_in;
      end
      for (int i = 0; i < 3; i++) begin
         ap_ff[i]    <= ap_in[i];
         bp_ff[i]    <= bp_in[i];
         ab_ff[i]    <= ab_in[i];
         ap_sq_ff[i] <= ap_sq_in[i];
         bp_sq_ff[i] <= bp_sq_in[i];
         ab_sq_ff[i] <= ab_sq_in[i];
         ap_ab_ff[i] <= ap_ab_in[i];
      end
      s1_radius_ff <= radius_ff;
      r2_ff        <= r2_in;
      sap_ff       <= sap_in;
      sbp_ff       <= sbp_in;
      len2_ff      <= len2_in;
      dot_ff       <= dot_in;
      s3_r2_ff     <= r2_ff;
      excess_ff    <= excess_in;
      proj_ff      <= proj_in;
      s4_len2_ff   <= len2_ff;
   end

   // Wide products for the interior case
   psr_wide_mul #(
      .WIDTH (PW)
   ) u_lhs_mul (
      .clock (clock),
      .mul_a (excess_ff),
      .mul_b (s4_len2_ff),
      .mul_p (lhs_prod)
   );

   psr_wide_mul #(
      .WIDTH (PW)
   ) u_rhs_mul (
      .clock (clock),
      .mul_a (proj_ff),
      .mul_b (proj_ff),
      .mul_p (rhs_prod)
   );

   // Carry the settled outcome alongside the multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MUL_STAGES; i++) begin
            mul_tag_ff[i] <= '0;
         end
      end else begin
         mul_tag_ff[0] <= s4_tag_ff;
         for (int i = 1; i < MUL_STAGES; i++) begin
            mul_tag_ff[i] <= mul_tag_ff[i-1];
         end
      end
   end

   // Final compare and output register
   assign out_inside_in = mul_tag_ff[MUL_STAGES-1].known ? mul_tag_ff[MUL_STAGES-1].value
                                                         : (lhs_prod <= rhs_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mul_tag_ff[MUL_STAGES-1].valid;
      end
      out_inside_ff <= out_inside_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_inside_res = out_inside_ff;

endmodule

// ===== src/psr_wide_mul.sv =====
// Pipelined unsigned multiplier for wide operands, split into halves.
// Three register stages: partial products, middle sum, final add.
// Depends on nothing outside this file.
module psr_wide_mul #(
   parameter int WIDTH = 42
) (
   input  logic                 clock,
   input  logic [WIDTH-1:0]     mul_a,
   input  logic [WIDTH-1:0]     mul_b,
   output logic [2*WIDTH-1:0]   mul_p
);

   localparam int LO = (WIDTH + 1) / 2;
   localparam int HI = WIDTH - LO;

   logic [LO-1:0]       a_lo, b_lo;
   logic [HI-1:0]       a_hi, b_hi;

   logic [2*LO-1:0]     ll_ff, ll_in;
   logic [LO+HI-1:0]    lh_ff, lh_in;
   logic [LO+HI-1:0]    hl_ff, hl_in;
   logic [2*HI-1:0]     hh_ff, hh_in;

   logic [WIDTH:0]      mid_ff, mid_in;
   logic [2*WIDTH-1:0]  cat_ff, cat_in;

   logic [2*WIDTH-1:0]  prod_ff, prod_in;

   // Split the operands into low and high halves
   assign a_lo = mul_a[LO-1:0];
   assign a_hi = mul_a[WIDTH-1:LO];
   assign b_lo = mul_b[LO-1:0];
   assign b_hi = mul_b[WIDTH-1:LO];

   // Form the four partial products
   assign ll_in = (2*LO)'(a_lo) * (2*LO)'(b_lo);
   assign lh_in = (LO+HI)'(a_lo) * (LO+HI)'(b_hi);
   assign hl_in = (LO+HI)'(a_hi) * (LO+HI)'(b_lo);
   assign hh_in = (2*HI)'(a_hi) * (2*HI)'(b_hi);

   // Merge the cross terms; outer terms do not overlap, so concatenate
   assign mid_in = (WIDTH+1)'(lh_ff) + (WIDTH+1)'(hl_ff);
   assign cat_in = {hh_ff, ll_ff};

   // Add the shifted cross terms into the outer terms
   assign prod_in = cat_ff + ((2*WIDTH)'(mid_ff) << LO);

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      mid_ff  <= mid_in;
      cat_ff  <= cat_in;
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// ===== src/psr_checker.sv =====
// Port-level checker for the point-to-segment radius test, with its bind.
// Depends on psr_pkg and binds to point_segment_radius_test.
module psr_port_assert
   import psr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Every transfer gives its result after a fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("result missing after request transfer");

   // No result appears without a matching transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result strobe without matching request");

   // Reset drops everything in flight
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // The block takes a request in every cycle outside reset
   assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy raised outside reset");

endmodule

bind point_segment_radius_test psr_port_assert u_psr_port_assert (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
